>>> design/rws_pkg.sv
// shared types, constants and codes for the roulette wheel selection block
package rws_pkg;

    // field widths
    localparam int FIT_W     = 16;
    localparam int SUM_W     = 22;
    localparam int RND_W     = 31;
    localparam int WHOLE_W   = 15;
    localparam int OFF_W     = 8;
    localparam int IDX_OUT_W = 6;
    localparam int FRAC_W    = 8;
    localparam int DIV_CNT_W = 5;

    // last step of the bit-serial modulo, one step per random bit
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd30;

    // half of one in q15.8, for round half up of the wheel total
    localparam logic [SUM_W:0] ROUND_HALF = 23'd128;

    // saturation value of an offspring count
    localparam logic [OFF_W-1:0] OFF_MAX = 8'hFF;

    // opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_SPIN  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic [IDX_OUT_W-1:0] t_idx_out;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [FIT_W-1:0] fitness;
        logic [RND_W-1:0] random_word;
    } t_in_word;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] selected_index;
        logic [OFF_W-1:0]     offspring_count;
        logic [SUM_W-1:0]     wheel_total;
        logic [1:0]           status;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_BS_RD,
        S_BS_CMP,
        S_CNT_RD,
        S_CNT_WR,
        S_PUSH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic bs_rd;
        logic bs_cmp;
        logic cnt_rd;
        logic cnt_wr;
        logic push;
    } t_rws_cmd;

    // datapath to controller
    typedef struct packed {
        logic spin_go;
        logic div_last;
        logic bs_done;
        logic out_free;
    } t_rws_sts;

endpackage

>>> design/rws_ctrl.sv
// controller state machine sequencing accept, then for a spin modulo, search and count update, then output
module rws_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  rws_pkg::t_rws_sts i_sts,
    output logic              o_in_ready,
    output rws_pkg::t_rws_cmd o_cmd
);

    rws_pkg::t_state r_state;
    rws_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rws_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.spin_go ? rws_pkg::S_DIV : rws_pkg::S_PUSH;
                end
            end
            rws_pkg::S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = rws_pkg::S_BS_RD;
                end
            end
            rws_pkg::S_BS_RD: begin
                n_state = i_sts.bs_done ? rws_pkg::S_CNT_RD : rws_pkg::S_BS_CMP;
            end
            rws_pkg::S_BS_CMP: n_state = rws_pkg::S_BS_RD;
            rws_pkg::S_CNT_RD: n_state = rws_pkg::S_CNT_WR;
            rws_pkg::S_CNT_WR: n_state = rws_pkg::S_PUSH;
            rws_pkg::S_PUSH: begin
                if (i_sts.out_free) begin
                    n_state = rws_pkg::S_IDLE;
                end
            end
            default: n_state = rws_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rws_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            rws_pkg::S_DIV:    o_cmd.div_step = 1'b1;
            rws_pkg::S_BS_RD:  o_cmd.bs_rd    = !i_sts.bs_done;
            rws_pkg::S_BS_CMP: o_cmd.bs_cmp   = 1'b1;
            rws_pkg::S_CNT_RD: o_cmd.cnt_rd   = 1'b1;
            rws_pkg::S_CNT_WR: o_cmd.cnt_wr   = 1'b1;
            rws_pkg::S_PUSH:   o_cmd.push     = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> design/rws_datapath.sv
// datapath: wheel memories, bit-serial modulo, binary search and output register
module rws_datapath #(
    parameter int POPULATION_SIZE = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rws_pkg::t_in_word  i_in_word,
    input  rws_pkg::t_rws_cmd  i_cmd,
    input  logic               i_out_ready,
    output rws_pkg::t_rws_sts  o_sts,
    output logic               o_out_valid,
    output rws_pkg::t_out_word o_out_word
);

    localparam int IDX_W = $clog2(POPULATION_SIZE);
    localparam int CNT_W = $clog2(POPULATION_SIZE + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POPULATION_SIZE);

    // wheel state
    logic [rws_pkg::SUM_W-1:0]  r_total;
    logic [CNT_W-1:0]           r_loaded;
    logic [POPULATION_SIZE-1:0] r_cnt_vld;
    logic [rws_pkg::SUM_W-1:0]  sum_mem [POPULATION_SIZE];
    logic [rws_pkg::OFF_W-1:0]  cnt_mem [POPULATION_SIZE];

    // spin working registers
    logic [rws_pkg::RND_W-1:0]     r_div;
    logic [rws_pkg::WHOLE_W-1:0]   r_rem;
    logic [rws_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [IDX_W-1:0]              r_lo;
    logic [IDX_W-1:0]              r_hi;
    logic [rws_pkg::SUM_W-1:0]     r_sum_rd;
    logic [rws_pkg::OFF_W-1:0]     r_cnt_rd;
    logic                          r_cnt_rd_vld;
    rws_pkg::t_out_word            r_res;
    rws_pkg::t_out_word            n_res;
    rws_pkg::t_out_word            r_out_word;
    logic                          r_out_valid;

    logic [rws_pkg::SUM_W-1:0]   w_new_sum;
    logic [IDX_W-1:0]            w_slot;
    logic [IDX_W-1:0]            w_last;
    logic                        w_full;
    logic [rws_pkg::SUM_W:0]     w_round;
    logic [rws_pkg::WHOLE_W-1:0] w_whole;
    logic [rws_pkg::WHOLE_W:0]   w_trial;
    logic [rws_pkg::WHOLE_W:0]   w_diff;
    logic [rws_pkg::WHOLE_W-1:0] n_rem;
    logic [rws_pkg::SUM_W:0]     w_land;
    logic                        w_ge_land;
    logic [IDX_W:0]              w_lohi;
    logic [IDX_W-1:0]            w_mid;
    logic [rws_pkg::OFF_W-1:0]   n_cnt;
    logic                        w_load_wr;

    // wheel bookkeeping
    assign w_new_sum = r_total + rws_pkg::SUM_W'(i_in_word.fitness);
    assign w_slot    = r_loaded[IDX_W-1:0];
    assign w_last    = IDX_W'(r_loaded - 1'b1);
    assign w_full    = (r_loaded == FULL_CNT);
    assign w_load_wr = i_cmd.accept && (i_in_word.opcode == rws_pkg::OP_LOAD) && !w_full;

    // total rounded half up to a whole number
    assign w_round = {1'b0, r_total} + rws_pkg::ROUND_HALF;
    assign w_whole = w_round[rws_pkg::SUM_W -: rws_pkg::WHOLE_W];

    // one restoring step of the modulo
    assign w_trial = {r_rem, r_div[rws_pkg::RND_W-1]};
    assign w_diff  = w_trial - {1'b0, w_whole};
    assign n_rem   = (w_trial >= {1'b0, w_whole}) ? w_diff[rws_pkg::WHOLE_W-1:0]
                                                  : w_trial[rws_pkg::WHOLE_W-1:0];

    // landing point in q15.8 against the running sum just read
    assign w_land    = {r_rem, rws_pkg::FRAC_W'(0)};
    assign w_ge_land = ({1'b0, r_sum_rd} >= w_land);
    assign w_lohi    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_lohi[IDX_W:1];

    // saturating offspring count, an unspun slot reads as zero
    always_comb begin
        if (!r_cnt_rd_vld) begin
            n_cnt = rws_pkg::OFF_W'(1);
        end else if (r_cnt_rd == rws_pkg::OFF_MAX) begin
            n_cnt = rws_pkg::OFF_MAX;
        end else begin
            n_cnt = r_cnt_rd + 1'b1;
        end
    end

    // status to the controller
    assign o_sts.spin_go  = (i_in_word.opcode == rws_pkg::OP_SPIN) && (r_loaded != '0)
                            && (w_whole != '0);
    assign o_sts.div_last = (r_div_cnt == rws_pkg::DIV_LAST);
    assign o_sts.bs_done  = (r_lo == r_hi);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // wheel control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_loaded  <= '0;
            r_cnt_vld <= '0;
        end else begin
            if (i_cmd.accept && (i_in_word.opcode == rws_pkg::OP_CLEAR)) begin
                r_total   <= '0;
                r_loaded  <= '0;
                r_cnt_vld <= '0;
            end else if (w_load_wr) begin
                r_total           <= w_new_sum;
                r_loaded          <= r_loaded + 1'b1;
                r_cnt_vld[w_slot] <= 1'b0;
            end else if (i_cmd.cnt_wr) begin
                r_cnt_vld[r_lo] <= 1'b1;
            end
        end
    end

    // running sum memory
    always_ff @(posedge i_clk) begin
        if (w_load_wr) begin
            sum_mem[w_slot] <= w_new_sum;
        end
        if (i_cmd.bs_rd) begin
            r_sum_rd <= sum_mem[w_mid];
        end
    end

    // offspring count memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_wr) begin
            cnt_mem[r_lo] <= n_cnt;
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_rd     <= cnt_mem[r_lo];
            r_cnt_rd_vld <= r_cnt_vld[r_lo];
        end
    end

    // modulo step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // modulo and search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_div <= i_in_word.random_word;
            r_rem <= '0;
            r_lo  <= '0;
            r_hi  <= w_last;
        end else if (i_cmd.div_step) begin
            r_div <= r_div << 1;
            r_rem <= n_rem;
        end else if (i_cmd.bs_cmp) begin
            if (w_ge_land) begin
                r_hi <= w_mid;
            end else begin
                r_lo <= w_mid + 1'b1;
            end
        end
    end

    // result word as taken at accept
    always_comb begin
        n_res = '{selected_index: '0, offspring_count: '0,
                  wheel_total: r_total, status: rws_pkg::ST_OK};
        case (i_in_word.opcode)
            rws_pkg::OP_CLEAR: n_res.wheel_total = '0;
            rws_pkg::OP_LOAD: begin
                if (w_full) begin
                    n_res.status = rws_pkg::ST_FULL;
                end else begin
                    n_res.selected_index = rws_pkg::t_idx_out'(w_slot);
                    n_res.wheel_total    = w_new_sum;
                end
            end
            rws_pkg::OP_SPIN: begin
                if (!o_sts.spin_go) begin
                    n_res.status = rws_pkg::ST_EMPTY;
                end
            end
            default: n_res.status = rws_pkg::ST_OK;
        endcase
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res <= n_res;
        end else if (i_cmd.cnt_wr) begin
            r_res <= '{selected_index: rws_pkg::t_idx_out'(r_lo), offspring_count: n_cnt,
                       wheel_total: r_res.wheel_total, status: r_res.status};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_word <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> design/roulette_wheel_selection.sv
// Roulette wheel selection: clear and load go from acceptance straight to the output push.
// A spin runs a bit-serial modulo of the random word by the rounded wheel total, then a
// binary search over the monotonic running sums, each probe a read of the sum memory's
// registered read port and then a compare, then a count read and write back.
// One word is in work at a time; the result waits in an output register.
// Synchronous active-low reset empties the wheel at once; no clearing pass is needed.
module roulette_wheel_selection #(
    parameter int POPULATION_SIZE = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rws_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rws_pkg::t_out_word o_out_word
);

    rws_pkg::t_rws_cmd w_cmd;
    rws_pkg::t_rws_sts w_sts;

    // sequencer
    rws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // wheel storage and arithmetic
    rws_datapath #(
        .POPULATION_SIZE (POPULATION_SIZE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

>>> design/rws_checker.sv
// port-level checks for the roulette wheel selection block, bound to the top level
module rws_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input rws_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input rws_pkg::t_out_word o_out_word
);

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one word in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a word is in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed");

    // a full-table result names no individual
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == rws_pkg::ST_FULL)
        |-> (o_out_word.selected_index == '0) && (o_out_word.offspring_count == '0))
        else $error("full-table result carries an index or count");

    // an empty-wheel result only comes with a total below one half
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == rws_pkg::ST_EMPTY)
        |-> (o_out_word.wheel_total < 22'd128) && (o_out_word.offspring_count == '0))
        else $error("empty-wheel result with a spinnable total");

endmodule

bind roulette_wheel_selection rws_checker u_rws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

>>> verif/tb_roulette_wheel_selection.sv
// testbench for roulette_wheel_selection: random and directed words checked against a predictor
`timescale 1ns / 100ps

module tb_roulette_wheel_selection;

    localparam int POP_SIZE = 32;
    localparam int N_ITEMS = 1250;
    localparam int SAT_SPINS = 258;
    localparam int TAIL_CYCLES = 100;
    // opcode that the block treats as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // wheel predictor and store of expected result words
    class wheel_scoreboard;
        logic [rws_pkg::SUM_W-1:0] run_sum [POP_SIZE];
        logic [rws_pkg::OFF_W-1:0] pick_cnt [POP_SIZE];
        int unsigned n_loaded;
        rws_pkg::t_out_word want_q[$];
        int unsigned errors;

        function new();
            empty_wheel();
            errors = 0;
        endfunction

        function void empty_wheel();
            foreach (run_sum[k]) begin
                run_sum[k] = '0;
                pick_cnt[k] = '0;
            end
            n_loaded = 0;
        endfunction

        function int unsigned pending();
            return want_q.size();
        endfunction

        // predict the result of one accepted input word
        function void note_word(rws_pkg::t_in_word w);
            rws_pkg::t_out_word r;
            logic [rws_pkg::SUM_W-1:0] total;
            int unsigned whole;
            int unsigned land;
            int unsigned j;
            total = (n_loaded == 0) ? '0 : run_sum[n_loaded-1];
            r = '0;
            r.wheel_total = total;
            r.status = rws_pkg::ST_OK;
            case (w.opcode)
                rws_pkg::OP_CLEAR: begin
                    empty_wheel();
                    r.wheel_total = '0;
                end
                rws_pkg::OP_LOAD: begin
                    if (n_loaded >= POP_SIZE) begin
                        r.status = rws_pkg::ST_FULL;
                    end else begin
                        run_sum[n_loaded] = total + w.fitness;
                        pick_cnt[n_loaded] = '0;
                        r.selected_index = rws_pkg::t_idx_out'(n_loaded);
                        r.wheel_total = run_sum[n_loaded];
                        n_loaded++;
                    end
                end
                rws_pkg::OP_SPIN: begin
                    // round half up to a whole number of fitness units
                    whole = (32'(total) + 32'd128) >> 8;
                    if (n_loaded == 0 || whole == 0) begin
                        r.status = rws_pkg::ST_EMPTY;
                    end else begin
                        land = (32'(w.random_word) % whole) << 8;
                        j = 0;
                        // first running sum at or past the landing point, clamped
                        while (j < n_loaded - 1 && land > 32'(run_sum[j]))
                            j++;
                        if (pick_cnt[j] != rws_pkg::OFF_MAX)
                            pick_cnt[j]++;
                        r.selected_index = rws_pkg::t_idx_out'(j);
                        r.offspring_count = pick_cnt[j];
                    end
                end
                default: begin
                end
            endcase
            want_q.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        // compare one accepted result word with the oldest prediction
        task check_word(rws_pkg::t_out_word got);
            rws_pkg::t_out_word want;
            if (want_q.size() == 0) begin
                report($sformatf("result word %h with nothing expected", got));
                return;
            end
            want = want_q.pop_front();
            if (got.selected_index !== want.selected_index)
                report($sformatf("selected_index %0d, expected %0d",
                    got.selected_index, want.selected_index));
            if (got.offspring_count !== want.offspring_count)
                report($sformatf("offspring_count %0d, expected %0d",
                    got.offspring_count, want.offspring_count));
            if (got.wheel_total !== want.wheel_total)
                report($sformatf("wheel_total %h, expected %h",
                    got.wheel_total, want.wheel_total));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
        endtask
    endclass

    logic i_clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    rws_pkg::t_in_word in_word = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    rws_pkg::t_out_word out_word;

    wheel_scoreboard board = new();
    int unsigned items_sent = 0;
    int unsigned send_idle_pct = 37;
    int unsigned recv_idle_pct = 72;

    roulette_wheel_selection #(
        .POPULATION_SIZE(POP_SIZE)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard limit on run length
    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls, check each accepted word
    initial begin
        forever begin
            @(posedge i_clk);
            if (rst_n && out_valid && out_ready)
                board.check_word(out_word);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic rws_pkg::t_in_word make_word(logic [1:0] op,
                                                     logic [rws_pkg::FIT_W-1:0] fit,
                                                     logic [rws_pkg::RND_W-1:0] rnd);
        rws_pkg::t_in_word w;
        w.opcode = op;
        w.fitness = fit;
        w.random_word = rnd;
        return w;
    endfunction

    function automatic logic [rws_pkg::FIT_W-1:0] rand_fit();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return rws_pkg::FIT_W'($urandom_range(0, 40));
            default: return rws_pkg::FIT_W'($urandom());
        endcase
    endfunction

    function automatic logic [rws_pkg::RND_W-1:0] rand_rnd();
        case ($urandom_range(7))
            0: return '1;
            1: return rws_pkg::RND_W'($urandom_range(0, 1000));
            default: return rws_pkg::RND_W'($urandom());
        endcase
    endfunction

    // present one word, hold it until accepted, then note it
    task automatic send_word(input rws_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        board.note_word(w);
        items_sent++;
    endtask

    // drop valid and hold off until every expected word has come
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // one random sequence: mostly clear, loads, spins; sometimes noise
    task automatic run_episode();
        int unsigned n_load;
        int unsigned n_spin;
        int unsigned k;
        if ($urandom_range(99) < 82) begin
            if ($urandom_range(3) != 0)
                send_word(make_word(rws_pkg::OP_CLEAR, rand_fit(), rand_rnd()));
            if ($urandom_range(9) == 0)
                n_load = $urandom_range(POP_SIZE - 6, POP_SIZE + 2);
            else
                n_load = $urandom_range(1, 8);
            for (k = 0; k < n_load; k++)
                send_word(make_word(rws_pkg::OP_LOAD, rand_fit(), rand_rnd()));
            n_spin = $urandom_range(1, 12);
            for (k = 0; k < n_spin; k++)
                send_word(make_word(rws_pkg::OP_SPIN, rand_fit(), rand_rnd()));
        end else begin
            n_spin = $urandom_range(1, 6);
            for (k = 0; k < n_spin; k++)
                send_word(make_word(2'($urandom_range(3)), rand_fit(), rand_rnd()));
        end
    endtask

    // main stimulus
    initial begin
        int unsigned k;
        int unsigned phase;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed: empty wheel, unused opcode, zero and rounding edges
        send_word(make_word(rws_pkg::OP_SPIN, '1, '1));
        send_word(make_word(OP_UNUSED, '1, '1));
        send_word(make_word(rws_pkg::OP_LOAD, '0, '0));
        send_word(make_word(rws_pkg::OP_SPIN, '0, '1));
        send_word(make_word(rws_pkg::OP_LOAD, 16'h007F, '0));
        send_word(make_word(rws_pkg::OP_SPIN, '1, 31'h2AAA_AAAA));
        send_word(make_word(rws_pkg::OP_LOAD, 16'h0001, '1));
        send_word(make_word(rws_pkg::OP_SPIN, '0, '1));
        send_word(make_word(rws_pkg::OP_CLEAR, '1, '1));
        send_word(make_word(rws_pkg::OP_LOAD, 16'h0100, '0));
        send_word(make_word(rws_pkg::OP_LOAD, 16'h0000, '0));
        send_word(make_word(rws_pkg::OP_LOAD, 16'h0100, '0));
        send_word(make_word(rws_pkg::OP_SPIN, '0, 31'd1));
        send_word(make_word(rws_pkg::OP_SPIN, '0, 31'd0));
        send_word(make_word(rws_pkg::OP_SPIN, '0, 31'd3));
        send_word(make_word(rws_pkg::OP_LOAD, '1, 31'h5555_5555));
        send_word(make_word(rws_pkg::OP_LOAD, 16'h8000, '1));
        send_word(make_word(rws_pkg::OP_SPIN, 16'hAAAA, '1));
        send_word(make_word(rws_pkg::OP_SPIN, 16'h5555, 31'h5555_5555));
        send_word(make_word(OP_UNUSED, '0, '0));
        send_word(make_word(rws_pkg::OP_CLEAR, '0, '0));
        send_word(make_word(rws_pkg::OP_SPIN, '1, '1));

        // random part in three idling phases
        phase = 0;
        while (items_sent < N_ITEMS) begin
            if (phase == 0 && items_sent >= N_ITEMS / 3) begin
                drain();
                phase = 1;
                send_idle_pct = 72;
                recv_idle_pct = 37;
            end else if (phase == 1 && items_sent >= 2 * N_ITEMS / 3) begin
                phase = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // one-entry wheel spun past offspring count saturation
                send_word(make_word(rws_pkg::OP_CLEAR, rand_fit(), rand_rnd()));
                send_word(make_word(rws_pkg::OP_LOAD,
                    rws_pkg::FIT_W'($urandom_range(16'h0100, 16'hFFFF)), rand_rnd()));
                for (k = 0; k < SAT_SPINS; k++)
                    send_word(make_word(rws_pkg::OP_SPIN, rand_fit(), rand_rnd()));
            end
            run_episode();
        end

        // wait out remaining results and a short tail
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
